@@ src/tkps_pkg.sv @@
// Package with shared types and constants for the top-k pair sums unit.
`timescale 1ns / 1ps
package tkps_pkg;
    localparam int MaxElems = 16;
    localparam int MaxK     = 64;
    localparam int IdxW     = $clog2(MaxElems);
    localparam int CntW     = $clog2(MaxElems + 1);
    localparam int KW       = 7;
    localparam int ValW     = 16;
    localparam int SumW     = 17;

    typedef struct packed {
        logic [ValW-1:0] a_value;
        logic [ValW-1:0] b_value;
        logic            is_last;
        logic [KW-1:0]   result_count;
    } in_t;

    typedef struct packed {
        logic [SumW-1:0] pair_sum;
        logic            is_last_result;
    } out_t;

    typedef logic [ValW-1:0] store_t [MaxElems];

    typedef struct packed {
        logic [MaxElems-1:0][ValW-1:0] a_vals;
        logic [MaxElems-1:0][ValW-1:0] b_vals;
        logic [CntW-1:0]               n;
        logic [KW-1:0]                 k;
    } job_t;
endpackage

@@ src/tkps_front.sv @@
// Front end: sorted insertion of incoming pairs and a two-entry job queue.
`timescale 1ns / 1ps
module tkps_front
    import tkps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  in_t   in_item,
    output logic  job_valid,
    input  logic  job_ready,
    output job_t  job
);
    logic [ValW-1:0] a_reg [MaxElems];
    logic [ValW-1:0] b_reg [MaxElems];
    logic [ValW-1:0] a_next [MaxElems];
    logic [ValW-1:0] b_next [MaxElems];
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            accept;
    logic            load;
    logic [MaxElems-1:0] a_ge;
    logic [MaxElems-1:0] b_ge;
    logic [2*CntW-1:0] nn;
    logic [KW-1:0]     k_cap;
    logic [KW-1:0]     k_val;
    job_t              new_job;

    job_t            q_mem [2];
    logic            q_wp_reg;
    logic            q_rp_reg;
    logic [1:0]      q_cnt_reg;
    logic            q_push;
    logic            q_pop;

    assign full   = (q_cnt_reg == 2'd2);
    assign accept = push && !full;
    assign load   = accept && (cnt_reg < CntW'(MaxElems));

    always_comb
    begin
        for (int p = 0; p < MaxElems; p++)
        begin
            a_ge[p] = (CntW'(p) < cnt_reg) && (a_reg[p] >= in_item.a_value);
            b_ge[p] = (CntW'(p) < cnt_reg) && (b_reg[p] >= in_item.b_value);
        end
        for (int p = 0; p < MaxElems; p++)
        begin
            if (a_ge[p])
                a_next[p] = a_reg[p];
            else if (p == 0)
                a_next[p] = in_item.a_value;
            else if (a_ge[p-1])
                a_next[p] = in_item.a_value;
            else
                a_next[p] = a_reg[p-1];
            if (b_ge[p])
                b_next[p] = b_reg[p];
            else if (p == 0)
                b_next[p] = in_item.b_value;
            else if (b_ge[p-1])
                b_next[p] = in_item.b_value;
            else
                b_next[p] = b_reg[p-1];
        end
    end

    assign cnt_next = load ? cnt_reg + CntW'(1) : cnt_reg;
    assign nn       = {{CntW{1'b0}}, cnt_next} * {{CntW{1'b0}}, cnt_next};
    assign k_cap    = (in_item.result_count > KW'(MaxK)) ? KW'(MaxK) : in_item.result_count;
    assign k_val    = ({(2*CntW)'(0), k_cap} > {{KW{1'b0}}, nn}) ? nn[KW-1:0] : k_cap;

    always_comb
    begin
        for (int p = 0; p < MaxElems; p++)
        begin
            new_job.a_vals[p] = load ? a_next[p] : a_reg[p];
            new_job.b_vals[p] = load ? b_next[p] : b_reg[p];
        end
        new_job.n = cnt_next;
        new_job.k = k_val;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int p = 0; p < MaxElems; p++)
            begin
                a_reg[p] <= a_next[p];
                b_reg[p] <= b_next[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= in_item.is_last ? '0 : cnt_next;
    end

    // job queue toward the search engine
    assign q_push    = accept && in_item.is_last;
    assign q_pop     = job_valid && job_ready;
    assign job_valid = (q_cnt_reg != 2'd0);
    assign job       = q_mem[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wp_reg] <= new_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (q_push)
                q_wp_reg <= ~q_wp_reg;
            if (q_pop)
                q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, q_pop};
        end
    end
endmodule

@@ src/tkps_back.sv @@
// Back end: row-frontier search for the largest sums and a result queue.
`timescale 1ns / 1ps
module tkps_back
    import tkps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  job_valid,
    output logic  job_ready,
    input  job_t  job,
    output logic  empty,
    input  logic  pop,
    output out_t  out_item
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]      state_reg;
    logic [ValW-1:0] a_reg [MaxElems];
    logic [ValW-1:0] b_reg [MaxElems];
    logic [CntW-1:0] ptr_reg [MaxElems];
    logic [CntW-1:0] n_reg;
    logic [KW-1:0]   k_reg;
    logic [KW-1:0]   done_reg;
    logic [IdxW-1:0] idx_reg;
    logic            found_reg;
    logic [SumW-1:0] best_reg;
    logic [IdxW-1:0] brow_reg;
    logic [CntW-1:0] cur_ptr;
    logic [SumW-1:0] cur_sum;
    logic            take;
    logic            row_end;
    logic            final_res;

    localparam int OqDepth = 4;
    localparam int OqW     = $clog2(OqDepth);
    out_t            oq_mem [OqDepth];
    logic [OqW-1:0]  oq_wp_reg;
    logic [OqW-1:0]  oq_rp_reg;
    logic [OqW:0]    oq_cnt_reg;
    logic            oq_full;
    logic            oq_push;
    logic            oq_pop;

    assign job_ready = (state_reg == ST_IDLE);
    assign cur_ptr   = ptr_reg[idx_reg];
    assign cur_sum   = {1'b0, a_reg[idx_reg]} + {1'b0, b_reg[cur_ptr[IdxW-1:0]]};
    assign take      = (cur_ptr < n_reg) && (!found_reg || cur_sum > best_reg);
    assign row_end   = ({1'b0, idx_reg} == n_reg - CntW'(1));
    assign final_res = (done_reg + KW'(1) == k_reg);
    assign oq_full   = (oq_cnt_reg == (OqW+1)'(OqDepth));
    assign oq_push   = (state_reg == ST_EMIT) && !oq_full;
    assign oq_pop    = pop && !empty;
    assign empty     = (oq_cnt_reg == '0);
    assign out_item  = oq_mem[oq_rp_reg];

    always_ff @(posedge clk)
    begin
        if (job_valid && state_reg == ST_IDLE)
        begin
            for (int p = 0; p < MaxElems; p++)
            begin
                a_reg[p] <= job.a_vals[p];
                b_reg[p] <= job.b_vals[p];
            end
            n_reg <= job.n;
            k_reg <= job.k;
        end
        if (state_reg == ST_SCAN && take)
        begin
            best_reg <= cur_sum;
            brow_reg <= idx_reg;
        end
        if (oq_push)
            oq_mem[oq_wp_reg] <= '{pair_sum: best_reg, is_last_result: final_res};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            for (int p = 0; p < MaxElems; p++)
                ptr_reg[p] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        for (int p = 0; p < MaxElems; p++)
                            ptr_reg[p] <= '0;
                        done_reg  <= '0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (job.k != '0)
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (take)
                        found_reg <= 1'b1;
                    if (row_end)
                        state_reg <= ST_EMIT;
                    else
                        idx_reg <= idx_reg + IdxW'(1);
                end
                ST_EMIT:
                begin
                    if (!oq_full)
                    begin
                        // advance the winning row to its next column
                        ptr_reg[brow_reg] <= ptr_reg[brow_reg] + CntW'(1);
                        done_reg  <= done_reg + KW'(1);
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= final_res ? ST_IDLE : ST_SCAN;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= '0;
            oq_rp_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wp_reg <= oq_wp_reg + OqW'(1);
            if (oq_pop)
                oq_rp_reg <= oq_rp_reg + OqW'(1);
            oq_cnt_reg <= oq_cnt_reg + (OqW+1)'(oq_push) - (OqW+1)'(oq_pop);
        end
    end
endmodule

@@ src/top_k_pair_sums_unit.sv @@
// Top level of the top-k pair sums unit.
// Loading: one pair per cycle while full is low; a job of up to MaxElems pairs is queued when the last item is taken.
// Search: for each result the scan state visits every row frontier in turn, then the emit state queues the best sum.
// A taken job waits in the job queue until the search engine is idle; up to two jobs may wait.
// Reset (rst_n low, asynchronous) empties all queues and clears the pair count.
`timescale 1ns / 1ps
module top_k_pair_sums_unit
    import tkps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  in_item,
    output logic empty,
    input  logic pop,
    output out_t out_item
);
    logic job_valid;
    logic job_ready;
    job_t job;

    tkps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    tkps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );
endmodule

@@ src/tkps_checker.sv @@
// Port-level checker for the top-k pair sums unit, bound to the top level.
`timescale 1ns / 1ps
module tkps_checker
    import tkps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input in_t  in_item,
    input logic empty,
    input logic pop,
    input out_t out_item
);
    logic [7:0]      pend_reg;
    logic            in_run_reg;
    logic [SumW-1:0] prev_reg;
    logic            job_in;
    logic            job_out;

    assign job_in  = push && !full && in_item.is_last;
    assign job_out = pop && !empty && out_item.is_last_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            in_run_reg <= 1'b0;
            prev_reg   <= '0;
        end
        else
        begin
            if (job_in && !job_out && pend_reg != 8'hFF)
                pend_reg <= pend_reg + 8'd1;
            else if (!job_in && job_out && pend_reg != 8'd0)
                pend_reg <= pend_reg - 8'd1;
            if (pop && !empty)
            begin
                in_run_reg <= !out_item.is_last_result;
                prev_reg   <= out_item.pair_sum;
            end
        end
    end

    // results only after some job was submitted
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pend_reg != 8'd0)
        else $error("result shown with no job pending");

    // sums of one run never increase
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && in_run_reg) |-> out_item.pair_sum <= prev_reg)
        else $error("pair sums out of order");

    // a waiting result is not dropped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");
endmodule

bind top_k_pair_sums_unit tkps_checker u_chk (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the top-k pair sums unit: directed jobs, then random jobs.
`timescale 1ns / 1ps
module testbench;
    import tkps_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    in_t  in_item = '0;
    out_t out_item;

    top_k_pair_sums_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    always #4 clk = ~clk;

    logic [ValW-1:0] a_store [MaxElems];
    logic [ValW-1:0] b_store [MaxElems];
    int unsigned loaded;
    out_t sum_queue [$];
    int mismatches = 0;
    int sent_items = 0;
    int jobs_done = 0;
    int sums_checked = 0;

    // Insert into a descending store of the given length.
    task automatic insert_sorted(ref logic [ValW-1:0] st [MaxElems], input int cnt,
                                 input logic [ValW-1:0] v);
        int p;
        p = cnt;
        while (p > 0 && st[p-1] < v)
        begin
            st[p] = st[p-1];
            p--;
        end
        st[p] = v;
    endtask

    // Largest k pair sums of the loaded stores, in non-increasing order.
    task automatic predict_top_sums(input logic [KW-1:0] want);
        bit seen [MaxElems][MaxElems];
        logic [SumW-1:0] c_sum [$];
        int c_row [$];
        int c_col [$];
        int k;
        int n;
        int best;
        int r;
        int i;
        int j;
        out_t res;
        n = loaded;
        k = want;
        if (k > n * n) k = n * n;
        if (k > MaxK) k = MaxK;
        foreach (seen[x, y]) seen[x][y] = 0;
        if (n > 0)
        begin
            seen[0][0] = 1;
            c_sum = {c_sum, {1'b0, a_store[0]} + {1'b0, b_store[0]}};
            c_row = {c_row, 0};
            c_col = {c_col, 0};
        end
        for (r = 0; r < k && c_sum.size() > 0; r++)
        begin
            best = 0;
            for (int t = 1; t < c_sum.size(); t++)
                if (c_sum[t] > c_sum[best]) best = t;
            res.pair_sum = c_sum[best];
            res.is_last_result = (r + 1 == k);
            sum_queue = {sum_queue, res};
            i = c_row[best];
            j = c_col[best];
            c_sum.delete(best);
            c_row.delete(best);
            c_col.delete(best);
            if (i + 1 < n && !seen[i+1][j])
            begin
                seen[i+1][j] = 1;
                c_sum = {c_sum, {1'b0, a_store[i+1]} + {1'b0, b_store[j]}};
                c_row = {c_row, i + 1};
                c_col = {c_col, j};
            end
            if (j + 1 < n && !seen[i][j+1])
            begin
                seen[i][j+1] = 1;
                c_sum = {c_sum, {1'b0, a_store[i]} + {1'b0, b_store[j+1]}};
                c_row = {c_row, i};
                c_col = {c_col, j + 1};
            end
        end
        loaded = 0;
        jobs_done++;
    endtask

    task automatic send_pair(input logic [ValW-1:0] a, input logic [ValW-1:0] b,
                             input bit last, input logic [KW-1:0] k);
        int gap;
        push <= 1'b1;
        in_item <= '{a_value: a, b_value: b, is_last: last, result_count: k};
        @(posedge clk);
        while (full) @(posedge clk);
        if (loaded < MaxElems)
        begin
            insert_sorted(a_store, loaded, a);
            insert_sorted(b_store, loaded, b);
            loaded++;
        end
        sent_items++;
        if (last) predict_top_sums(k);
        // optional random idle gap before the next transaction
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Check each popped transaction against the oldest predicted sum.
    initial
    begin
        int wait_cycles;
        out_t exp_res;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (sum_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum=%0d last=%0b",
                             out_item.pair_sum, out_item.is_last_result);
            end
            else
            begin
                exp_res = sum_queue.pop_front();
                sums_checked++;
                if (out_item.pair_sum !== exp_res.pair_sum ||
                    out_item.is_last_result !== exp_res.is_last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected sum=%0d last=%0b, got sum=%0d last=%0b",
                                 exp_res.pair_sum, exp_res.is_last_result,
                                 out_item.pair_sum, out_item.is_last_result);
                end
            end
        end
    end

    task automatic send_job(input int n, input logic [KW-1:0] k, input int mode);
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
        for (int p = 0; p < n; p++)
        begin
            case (mode)
                1: begin a = 16'hFFFF; b = 16'hFFFF; end
                2: begin a = 16'd0; b = 16'd0; end
                3: begin a = 16'd7; b = 16'd7; end
                default: begin a = ValW'($urandom); b = ValW'($urandom); end
            endcase
            send_pair(a, b, p == n - 1, k);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_extremes();
        send_job(1, 7'd1, 1);
        send_job(1, 7'd1, 2);
        send_job(3, 7'd9, 1);
        send_job(2, 7'd0, 0);
        send_job(3, 7'd100, 3);
        send_pair(16'h0000, 16'hFFFF, 0, 7'd0);
        send_pair(16'hFFFF, 16'h0000, 0, 7'd0);
        send_pair(16'h5555, 16'hAAAA, 1, 7'h7F);
    endtask

    task automatic test_store_overflow();
        send_job(20, 7'd64, 0);
    endtask

    task automatic test_idle_between_jobs();
        wait_drained();
        send_job(4, 7'd16, 0);
        wait_drained();
    endtask

    task automatic test_random_jobs();
        int n;
        int k;
        while (sent_items < 170)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : $urandom_range(1, 6);
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, n * n);
            send_job(n, k[KW-1:0], $urandom_range(0, 5) == 0 ? 3 : 0);
        end
    endtask

    initial
    begin
        loaded = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_store_overflow();
        test_idle_between_jobs();
        test_random_jobs();
        wait_drained();
        $display("covered %0d pairs in %0d jobs, %0d sums checked",
                 sent_items, jobs_done, sums_checked);
        if (mismatches == 0 && sum_queue.size() == 0)
            $display("top_k_pair_sums_unit test passed");
        else
            $display("top_k_pair_sums_unit test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("top_k_pair_sums_unit test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
src/tkps_pkg.sv
src/tkps_front.sv
src/tkps_back.sv
src/top_k_pair_sums_unit.sv
src/tkps_checker.sv
tb/sv/testbench.sv
